>>> hw/rtl/surt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surt_pkg
// Shared types and codes for the sorted unique rank table.
// ----------------------------------------------------------------------------
package surt_pkg;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_t;

  // broadcast control to every cell
  typedef struct packed {
    logic ins;  // insert of a new value with room left
    logic clr;  // empty the table
  } cell_ctl_t;

endpackage

>>> hw/rtl/surt_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surt_in_if / surt_out_if
// Valid/ready channels carrying requests and results.
// ----------------------------------------------------------------------------
interface surt_in_if #(parameter int VW = 32);
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic signed [VW-1:0] value;

  modport source (output valid, output cmd, output value, input ready);
  modport sink   (input valid, input cmd, input value, output ready);
endinterface

interface surt_out_if #(parameter int CW = 7);
  logic          valid;
  logic          ready;
  logic [CW-1:0] rank;
  logic          present;
  logic [CW-1:0] entry_count;
  logic          overflow;

  modport source (output valid, output rank, output present, output entry_count,
                  output overflow, input ready);
  modport sink   (input valid, input rank, input present, input entry_count,
                  input overflow, output ready);
endinterface

>>> hw/rtl/sorted_unique_rank_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_unique_rank_table
// Sorted distinct-value table with lower-bound rank, held in a row of cells.
// ----------------------------------------------------------------------------
// Each accepted request writes its result into the result register.
// Throughput: one request per cycle while the result is not stalled; set by the
//   broadcast compare and shift across all TABLE_DEPTH cells.
// The result register frees in the same cycle it is taken.
// Reset: synchronous, clears the cell valid bits, count and result valid.
module sorted_unique_rank_table #(
  parameter int TABLE_DEPTH = 64,
  parameter int VALUE_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  surt_in_if.sink       in_ch,
  surt_out_if.source    out_ch
);

  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic signed [VALUE_WIDTH-1:0] cell_value [TABLE_DEPTH];
  logic signed [VALUE_WIDTH-1:0] left_value [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] valid_v, less_v, eq_v, bnd_v, left_less, left_valid;

  surt_pkg::cell_ctl_t ctl;
  logic                accept;
  logic                is_ins, is_clr, present_c, full, ins_new, ovf_c;
  logic [CW-1:0]       rank_c, cnt_nxt;

  logic          out_valid_r, out_valid_nxt;
  logic [CW-1:0] cnt_r;
  logic [CW-1:0] rank_r;
  logic          present_r, ovf_r;

  assign accept       = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = !out_valid_r || out_ch.ready;

  always_comb begin
    is_ins = 1'b0;
    is_clr = 1'b0;
    unique case (in_ch.cmd)
      surt_pkg::CMD_INSERT: is_ins = 1'b1;
      surt_pkg::CMD_CLEAR:  is_clr = 1'b1;
      default:              ;
    endcase
  end

  genvar gi;
  generate
    for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
      if (gi == 0) begin : g_head
        assign left_less[gi]  = 1'b1;
        assign left_valid[gi] = 1'b1;
        assign left_value[gi] = '0;
      end else begin : g_link
        assign left_less[gi]  = less_v[gi-1];
        assign left_valid[gi] = valid_v[gi-1];
        assign left_value[gi] = cell_value[gi-1];
      end

      surt_cell #(.W(VALUE_WIDTH)) u_cell (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (ctl),
        .key_i      (in_ch.value),
        .less_left  (left_less[gi]),
        .valid_left (left_valid[gi]),
        .value_left (left_value[gi]),
        .value_o    (cell_value[gi]),
        .valid_o    (valid_v[gi]),
        .less_o     (less_v[gi]),
        .eq_o       (eq_v[gi]),
        .boundary_o (bnd_v[gi])
      );
    end
  endgenerate

  // less bits form a thermometer, so the rank is the single boundary cell, or TABLE_DEPTH if all are less
  always_comb begin
    rank_c = '0;
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (bnd_v[i]) rank_c = rank_c | CW'(i);
    end
    if (less_v[TABLE_DEPTH-1]) rank_c = CW'(TABLE_DEPTH);
  end

  assign present_c = |eq_v;
  assign full      = (cnt_r == CW'(TABLE_DEPTH));
  assign ins_new   = is_ins && !present_c && !full;
  assign ovf_c     = is_ins && !present_c && full;
  assign ctl.ins   = accept && ins_new;
  assign ctl.clr   = accept && is_clr;

  always_comb begin
    priority if (is_clr) begin
      cnt_nxt = '0;
    end else if (ins_new) begin
      cnt_nxt = cnt_r + CW'(1);
    end else begin
      cnt_nxt = cnt_r;
    end
  end

  assign out_valid_nxt = accept || (out_valid_r && !out_ch.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rank_r    <= is_clr ? '0 : rank_c;
      present_r <= !is_clr && present_c;
      ovf_r     <= ovf_c;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.rank        = rank_r;
  assign out_ch.present     = present_r;
  assign out_ch.entry_count = cnt_r;
  assign out_ch.overflow    = ovf_r;

  a_cnt_matches_cells : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(valid_v) == int'(cnt_r))
    else $error("count differs from occupied cells");

  a_one_boundary : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(bnd_v))
    else $error("more than one rank boundary");

  a_ovf_only_full : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_r |-> cnt_r == CW'(TABLE_DEPTH))
    else $error("overflow reported on a table with room");

  a_clear_empties : assert property (@(posedge clk) disable iff (!rst_n)
    accept && is_clr |=> cnt_r == '0 && valid_v == '0)
    else $error("clear left entries behind");

  a_held_result : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ch.ready |-> !accept)
    else $error("request taken while result stalled");

endmodule

>>> hw/rtl/surt_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// surt_cell
// One table entry: compares against the broadcast key and shifts right on insert.
// ----------------------------------------------------------------------------
module surt_cell #(
  parameter int W = 32
) (
  input  logic                clk,
  input  logic                rst_n,
  input  surt_pkg::cell_ctl_t ctl,
  input  logic signed [W-1:0] key_i,
  input  logic                less_left,
  input  logic                valid_left,
  input  logic signed [W-1:0] value_left,
  output logic signed [W-1:0] value_o,
  output logic                valid_o,
  output logic                less_o,
  output logic                eq_o,
  output logic                boundary_o
);

  logic signed [W-1:0] value_r, value_nxt;
  logic                valid_r, valid_nxt;

  assign less_o     = valid_r && (value_r < key_i);
  assign eq_o       = valid_r && (value_r == key_i);
  assign boundary_o = less_left && !less_o;
  assign value_o    = value_r;
  assign valid_o    = valid_r;

  always_comb begin
    value_nxt = value_r;
    valid_nxt = valid_r;
    if (ctl.clr) begin
      valid_nxt = 1'b0;
    end else if (ctl.ins && !less_o) begin
      if (less_left) begin
        value_nxt = key_i;
        valid_nxt = 1'b1;
      end else begin
        value_nxt = value_left;
        valid_nxt = valid_left;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    value_r <= value_nxt;
  end

endmodule
